@@ rtl/cbbl_pkg.sv @@
// Shared constants, types and saturation helpers for the cascaded biquad band limiter.
`default_nettype none

package cbbl_pkg;

    localparam int MAX_SECTIONS = 8;
    localparam int DEPTH        = 2 * MAX_SECTIONS;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);

    localparam int SAMPLE_W     = 24;
    localparam int HIST_W       = 32;
    localparam int COEF_W       = 32;
    localparam int PROD_W       = HIST_W + COEF_W;
    localparam int ACC_W        = PROD_W + 4;
    localparam int FRAC_W       = 29;
    localparam int ENTRY_W      = 4 * HIST_W;
    localparam int COUNT_W      = 4;

    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;

    typedef enum logic [2:0] {
        REG_SECTION_COUNT = 3'd0,
        REG_HP_GAIN       = 3'd1,
        REG_HP_FB1        = 3'd2,
        REG_HP_FB2        = 3'd3,
        REG_LP_GAIN       = 3'd4,
        REG_LP_FB1        = 3'd5,
        REG_LP_FB2        = 3'd6
    } cfg_reg_t;

    // Round already applied by preload; drop fraction and clamp to history width.
    function automatic logic signed [HIST_W-1:0] acc_to_hist(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        logic                    fits;
        q    = acc >>> FRAC_W;
        fits = (&q[ACC_W-1:HIST_W-1]) | ~(|q[ACC_W-1:HIST_W-1]);
        if (fits)
            return q[HIST_W-1:0];
        else if (q[ACC_W-1])
            return {1'b1, {(HIST_W-1){1'b0}}};
        else
            return {1'b0, {(HIST_W-1){1'b1}}};
    endfunction

    function automatic logic [SAMPLE_W-1:0] hist_to_sample(input logic signed [HIST_W-1:0] x);
        logic fits;
        fits = (&x[HIST_W-1:SAMPLE_W-1]) | ~(|x[HIST_W-1:SAMPLE_W-1]);
        if (fits)
            return x[SAMPLE_W-1:0];
        else
            return {x[HIST_W-1], {(SAMPLE_W-1){~x[HIST_W-1]}}};
    endfunction

endpackage

`default_nettype wire

@@ rtl/cascaded_biquad_band_limiter.sv @@
// Top level: cascaded high-pass then low-pass biquad sections over a shared history memory.
// One item at a time: a new input is accepted only once the previous one has left the datapath.
// Each section takes one history read, five products on the single 32x32 multiplier, and one
// round/saturate/write-back step.
// A finished item waits in the output register while the next item is accepted.
// Reset clears control, configuration and the per-entry valid bits; history reads as zero
// until a section writes its entry.
`default_nettype none

module cascaded_biquad_band_limiter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cbbl_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cbbl_pkg::PDATA_W-1:0]  pwdata,
    output logic      [cbbl_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cbbl_pkg::SAMPLE_W-1:0] s_tdata,   // [23:0] sample_in
    // output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [cbbl_pkg::SAMPLE_W-1:0] m_tdata    // [23:0] sample_out
);

    import cbbl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_FIN,
        ST_OUT
    } state_t;

    // product order within one section
    localparam logic [2:0] TERM_FB1  = 3'd0;
    localparam logic [2:0] TERM_FB2  = 3'd1;
    localparam logic [2:0] TERM_X0   = 3'd2;
    localparam logic [2:0] TERM_X2   = 3'd3;
    localparam logic [2:0] TERM_X1   = 3'd4;
    localparam logic [2:0] STEP_LAST = 3'd5;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

    // configuration
    logic [COUNT_W-1:0]       section_count_reg;
    logic signed [COEF_W-1:0] hp_gain_reg, hp_fb1_reg, hp_fb2_reg;
    logic signed [COEF_W-1:0] lp_gain_reg, lp_fb1_reg, lp_fb2_reg;
    logic                     cfg_write;
    cfg_reg_t                 cfg_sel;

    // control
    state_t                   state_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         k_reg;
    logic                     band_reg;
    logic [2:0]               step_reg;
    logic [CNT_W-1:0]         n_eff;
    logic [ADDR_W-1:0]        addr;

    // datapath
    logic signed [HIST_W-1:0] x_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [HIST_W-1:0] y_new;

    // history memory, entry = {y2, y1, x2, x1}
    logic [ENTRY_W-1:0]       hist_mem [DEPTH];
    logic [ENTRY_W-1:0]       mem_q_reg;
    logic                     valid_q_reg;
    logic [DEPTH-1:0]         valid_reg;
    logic [ENTRY_W-1:0]       hist;
    logic signed [HIST_W-1:0] x1, x2, y1, y2;

    logic signed [COEF_W-1:0] gain, fb1, fb2;
    logic signed [COEF_W-1:0] op_a;
    logic signed [HIST_W-1:0] op_b;
    logic signed [ACC_W-1:0]  term;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_sel   = cfg_reg_t'(paddr[PADDR_W-1:2]);
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb
    begin
        case (cfg_sel)
            REG_SECTION_COUNT: prdata = PDATA_W'(section_count_reg);
            REG_HP_GAIN:       prdata = hp_gain_reg;
            REG_HP_FB1:        prdata = hp_fb1_reg;
            REG_HP_FB2:        prdata = hp_fb2_reg;
            REG_LP_GAIN:       prdata = lp_gain_reg;
            REG_LP_FB1:        prdata = lp_fb1_reg;
            REG_LP_FB2:        prdata = lp_fb2_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_count_reg <= '0;
            hp_gain_reg       <= '0;
            hp_fb1_reg        <= '0;
            hp_fb2_reg        <= '0;
            lp_gain_reg       <= '0;
            lp_fb1_reg        <= '0;
            lp_fb2_reg        <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_SECTION_COUNT: section_count_reg <= pwdata[COUNT_W-1:0];
                REG_HP_GAIN:       hp_gain_reg       <= pwdata;
                REG_HP_FB1:        hp_fb1_reg        <= pwdata;
                REG_HP_FB2:        hp_fb2_reg        <= pwdata;
                REG_LP_GAIN:       lp_gain_reg       <= pwdata;
                REG_LP_FB1:        lp_fb1_reg        <= pwdata;
                REG_LP_FB2:        lp_fb2_reg        <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(section_count_reg) > MAX_SECTIONS)
            n_eff = CNT_W'(MAX_SECTIONS);
        else
            n_eff = CNT_W'(section_count_reg);
    end

    // high-pass sections occupy the lower half of the memory, low-pass the upper half
    assign addr = band_reg ? ADDR_W'(MAX_SECTIONS) + ADDR_W'(k_reg) : ADDR_W'(k_reg);

    // entries never written read as zero
    assign hist = valid_q_reg ? mem_q_reg : '0;
    assign x1   = hist[HIST_W-1:0];
    assign x2   = hist[2*HIST_W-1:HIST_W];
    assign y1   = hist[3*HIST_W-1:2*HIST_W];
    assign y2   = hist[4*HIST_W-1:3*HIST_W];

    assign gain = band_reg ? lp_gain_reg : hp_gain_reg;
    assign fb1  = band_reg ? lp_fb1_reg  : hp_fb1_reg;
    assign fb2  = band_reg ? lp_fb2_reg  : hp_fb2_reg;

    always_comb
    begin
        case (step_reg)
            TERM_FB1:
            begin
                op_a = fb1;
                op_b = y1;
            end
            TERM_FB2:
            begin
                op_a = fb2;
                op_b = y2;
            end
            TERM_X0:
            begin
                op_a = gain;
                op_b = x_reg;
            end
            TERM_X2:
            begin
                op_a = gain;
                op_b = x2;
            end
            TERM_X1:
            begin
                op_a = gain;
                op_b = x1;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // accumulate the product issued in the previous step; the middle tap counts twice
    always_comb
    begin
        term = ACC_W'(prod_reg);
        if (step_reg == STEP_LAST)
        begin
            term = term <<< 1;
            if (!band_reg)
                term = -term;
        end
        acc_next = acc_reg + term;
    end

    assign y_new = acc_to_hist(acc_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            mem_q_reg   <= hist_mem[addr];
            valid_q_reg <= valid_reg[addr];
        end
        if (state_reg == ST_FIN)
            hist_mem[addr] <= {y1, y_new, x1, x_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (state_reg == ST_FIN)
            valid_reg[addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
            band_reg  <= 1'b0;
            step_reg  <= '0;
            m_tvalid  <= 1'b0;
            m_tdata   <= '0;
            x_reg     <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            // the output state either reloads or holds the output register itself
            if (m_tvalid && m_tready && state_reg != ST_OUT)
                m_tvalid <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        x_reg    <= HIST_W'(signed'(s_tdata));
                        n_reg    <= n_eff;
                        k_reg    <= '0;
                        band_reg <= 1'b0;
                        state_reg <= (n_eff == '0) ? ST_OUT : ST_READ;
                    end
                end
                ST_READ:
                begin
                    acc_reg   <= ROUND_HALF;
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg != TERM_FB1)
                        acc_reg <= acc_next;
                    if (step_reg == STEP_LAST)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    x_reg <= y_new;
                    if (CNT_W'(k_reg + 1'b1) == n_reg)
                    begin
                        k_reg <= '0;
                        if (band_reg)
                            state_reg <= ST_OUT;
                        else
                        begin
                            band_reg  <= 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_OUT:
                begin
                    // hold until the output register is free
                    if (!m_tvalid || m_tready)
                    begin
                        m_tdata   <= hist_to_sample(x_reg);
                        m_tvalid  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && n_eff == '0) |=> state_reg == ST_OUT)
        else $error("zero-section item did not go straight to output");

    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_MUL || state_reg == ST_FIN) |-> k_reg < n_reg)
        else $error("section index beyond active count");

    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |=> valid_reg[$past(addr)])
        else $error("written history entry not marked valid");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && m_tvalid && !m_tready) |=> state_reg == ST_OUT)
        else $error("result dropped while output register was full");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the cascaded biquad band limiter, with predictor, driver and monitor.
`timescale 1ns / 100ps

module tb_top;
    import cbbl_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16 * MAX_SECTIONS + 20;
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_ITEMS  = 50;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata  = '0;   // [23:0] sample_in
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;         // [23:0] sample_out

    cascaded_biquad_band_limiter DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // Filter state and register copy
    logic        [3:0]        sections;
    logic signed [HIST_W-1:0] hp_gain, hp_fb1, hp_fb2;
    logic signed [HIST_W-1:0] lp_gain, lp_fb1, lp_fb2;
    logic signed [HIST_W-1:0] hp_x [DEPTH];
    logic signed [HIST_W-1:0] hp_y [DEPTH];
    logic signed [HIST_W-1:0] lp_x [DEPTH];
    logic signed [HIST_W-1:0] lp_y [DEPTH];

    logic [SAMPLE_W-1:0] pending_samples [$];
    logic [SAMPLE_W-1:0] expected_out [$];
    int                  errors = 0;
    int                  cycles = 0;
    bit                  in_taken = 1'b0;
    bit                  calm = 1'b0;
    int                  src_gap = 0;
    int                  sink_stall = 0;

    function automatic void clear_filter();
        sections = '0;
        hp_gain = '0; hp_fb1 = '0; hp_fb2 = '0;
        lp_gain = '0; lp_fb1 = '0; lp_fb2 = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hp_x[i] = '0; hp_y[i] = '0; lp_x[i] = '0; lp_y[i] = '0;
        end
    endfunction

    // One section: exact sum of products, round half up at bit 29, clamp to 32 bits.
    function automatic logic signed [HIST_W-1:0] biquad_step(input logic signed [HIST_W-1:0] x,
                                                             input bit high, input int k);
        logic signed [71:0]       acc;
        logic signed [71:0]       tap;
        logic signed [71:0]       q;
        logic signed [HIST_W-1:0] g, f1, f2, x1, x2, y1, y2, y;
        if (high)
        begin
            g = hp_gain; f1 = hp_fb1; f2 = hp_fb2;
            x1 = hp_x[2*k]; x2 = hp_x[2*k+1]; y1 = hp_y[2*k]; y2 = hp_y[2*k+1];
        end
        else
        begin
            g = lp_gain; f1 = lp_fb1; f2 = lp_fb2;
            x1 = lp_x[2*k]; x2 = lp_x[2*k+1]; y1 = lp_y[2*k]; y2 = lp_y[2*k+1];
        end
        acc = f1 * y1;
        acc = acc + f2 * y2;
        acc = acc + g * x;
        acc = acc + g * x2;
        tap = g * x1;
        if (high)
            acc = acc - tap - tap;
        else
            acc = acc + tap + tap;
        acc = acc + (72'sd1 <<< 28);
        q = acc >>> FRAC_W;
        if (q > 72'sd2147483647)
            y = 32'sh7FFF_FFFF;
        else if (q < -72'sd2147483648)
            y = 32'sh8000_0000;
        else
            y = q[HIST_W-1:0];
        if (high)
        begin
            hp_x[2*k+1] = x1; hp_x[2*k] = x; hp_y[2*k+1] = y1; hp_y[2*k] = y;
        end
        else
        begin
            lp_x[2*k+1] = x1; lp_x[2*k] = x; lp_y[2*k+1] = y1; lp_y[2*k] = y;
        end
        return y;
    endfunction

    function automatic logic [SAMPLE_W-1:0] band_limit(input logic [SAMPLE_W-1:0] smp);
        logic signed [HIST_W-1:0] s;
        int                       n;
        s = {{(HIST_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
        n = (sections > MAX_SECTIONS) ? MAX_SECTIONS : int'(sections);
        for (int k = 0; k < n; k++)
            s = biquad_step(s, 1'b1, k);
        for (int k = 0; k < n; k++)
            s = biquad_step(s, 1'b0, k);
        if (s > 32'sd8388607)
            s = 32'sd8388607;
        else if (s < -32'sd8388608)
            s = -32'sd8388608;
        return s[SAMPLE_W-1:0];
    endfunction

    task automatic report(input string what, input logic [SAMPLE_W-1:0] got,
                          input logic [SAMPLE_W-1:0] want);
        $display("%0t sample_out %s: got %h wanted %h", $realtime, what, got, want);
        errors++;
    endtask

    // Accept side: predict on each input item, check each output item.
    always @(posedge clk)
    begin : watch
        logic [SAMPLE_W-1:0] want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_out.push_back(band_limit(s_tdata));
                in_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_out.size() == 0)
                    report("unexpected", m_tdata, 'x);
                else
                begin
                    want = expected_out.pop_front();
                    if (m_tdata !== want)
                        report("wrong", m_tdata, want);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cascaded_biquad_band_limiter: mismatch");
            $finish;
        end
    end

    // Source: hold an item until taken, otherwise idle in bursts or present the next one.
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_taken))
        begin
            in_taken = 1'b0;
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                src_gap = $urandom_range(0, 10);
                s_tvalid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                s_tdata  <= pending_samples.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Sink: stall in bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                sink_stall = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input cfg_reg_t r, input logic [PDATA_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_SECTION_COUNT: sections = v[3:0];
            REG_HP_GAIN:       hp_gain  = v;
            REG_HP_FB1:        hp_fb1   = v;
            REG_HP_FB2:        hp_fb2   = v;
            REG_LP_GAIN:       lp_gain  = v;
            REG_LP_FB1:        lp_fb1   = v;
            REG_LP_FB2:        lp_fb2   = v;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [3:0] cnt,
                             input logic [31:0] hg, input logic [31:0] h1, input logic [31:0] h2,
                             input logic [31:0] lg, input logic [31:0] l1, input logic [31:0] l2);
        write_reg(REG_SECTION_COUNT, {28'd0, cnt});
        write_reg(REG_HP_GAIN, hg);
        write_reg(REG_HP_FB1, h1);
        write_reg(REG_HP_FB2, h2);
        write_reg(REG_LP_GAIN, lg);
        write_reg(REG_LP_FB1, l1);
        write_reg(REG_LP_FB2, l2);
    endtask

    // Wait until every item has gone through and every result has come back.
    // Check at the rising edge, where s_tvalid and the pending queue are settled.
    task automatic drain();
        @(posedge clk);
        while (pending_samples.size() != 0 || s_tvalid || expected_out.size() != 0)
            @(posedge clk);
    endtask

    // role 0 = gain, 1 = feedback on y1, 2 = feedback on y2
    function automatic logic [31:0] pick_coef(input int mode, input int role);
        logic [31:0] v;
        case (mode)
            0:
            begin
                case (role)
                    0: v = $urandom_range(0, 32'h1000_0000);
                    1: v = $urandom_range(32'h1000_0000, 32'h3CCC_CCCC);
                    default: v = -$urandom_range(32'h0999_9999, 32'h1E66_6666);
                endcase
                if (role == 0 && $urandom_range(0, 1))
                    v = -v;
            end
            1: v = $urandom;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h2000_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return SAMPLE_W'($urandom);
        else if (r < 9)
            return SAMPLE_W'($urandom_range(0, 2000) - 1000);
        else
        begin
            case ($urandom_range(0, 3))
                0: return 24'h80_0000;
                1: return 24'h7F_FFFF;
                2: return 24'h00_0000;
                default: return 24'hFF_FFFF;
            endcase
        end
    endfunction

    initial
    begin : stimulus
        int          mode;
        logic [3:0]  cnt;
        clear_filter();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero sections: pass-through
        pending_samples = '{24'h00_0000, 24'h7F_FFFF, 24'h80_0000, 24'hFF_FFFF, 24'h00_0001,
                            24'h55_5555, 24'hAA_AAAA};
        drain();

        // One section, a usable high-pass / low-pass pair, step response
        write_all(4'd1, 32'h1C00_0000, 32'h3A00_0000, 32'hE600_0000,
                  32'h0100_0000, 32'h3800_0000, 32'hE800_0000);
        pending_samples = '{24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 24'h00_0000};
        drain();

        // Extreme coefficients at full depth: sections and output saturate
        write_all(4'd8, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        pending_samples = '{24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000};
        drain();

        // Count above the limit acts as full depth
        write_all(4'd15, 32'h1000_0000, 32'h2000_0000, 32'hF000_0000,
                  32'h1000_0000, 32'h2000_0000, 32'hF000_0000);
        pending_samples = '{24'h12_3456, 24'hED_CBA9, 24'h00_0100};
        drain();

        // Count change keeps history of unused sections
        write_reg(REG_SECTION_COUNT, 32'd3);
        pending_samples = '{24'h40_0000, 24'hC0_0000};
        drain();
        write_reg(REG_SECTION_COUNT, 32'd8);
        pending_samples = '{24'h00_0000, 24'h00_0001};
        drain();

        for (int ph = 0; ph <= RAND_PHASES; ph++)
        begin
            if ($urandom_range(0, 9) < 8)
                cnt = 4'($urandom_range(0, MAX_SECTIONS));
            else
                cnt = 4'($urandom_range(MAX_SECTIONS + 1, 15));
            mode = $urandom_range(0, 9);
            mode = (mode < 6) ? 0 : (mode < 8) ? 1 : 2;
            write_all(cnt, pick_coef(mode, 0), pick_coef(mode, 1), pick_coef(mode, 2),
                      pick_coef(mode, 0), pick_coef(mode, 1), pick_coef(mode, 2));
            if (ph == RAND_PHASES)
                calm = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_samples.push_back(pick_sample());
            drain();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("cascaded_biquad_band_limiter: match");
        else
            $display("cascaded_biquad_band_limiter: mismatch");
        $finish;
    end

endmodule
